// ----- sv/pasm_pkg.sv -----
// ----------------------------------------------------------------------------
// PWM angle sensor package
// Shared constants, register indexes and types for the PWM duty capture and
// multi-turn angle unwrap block.
// ----------------------------------------------------------------------------
package pasm_pkg;

   localparam int CountWidth   = 16;
   localparam int DutyWidth    = 10;
   localparam int AngleWidth   = 16;
   localparam int TotalWidth   = 32;
   localparam int JumpWidth    = 15;
   localparam int CsrIdxWidth  = 3;
   localparam int DvdWidth     = 26;
   localparam int DivCntWidth  = 5;

   localparam logic [DutyWidth-1:0]  DUTY_FULL   = 10'd1000;
   localparam logic [DvdWidth-1:0]   DUTY_FULL_Q = 26'd1000;
   localparam logic signed [AngleWidth-1:0] DUTY_OFFSET = 16'sd125;
   localparam logic signed [AngleWidth:0]   SPAN_CD     = 17'sd18000;
   localparam logic signed [AngleWidth-1:0] WRAP_LOW    = 16'sd2000;
   localparam logic signed [AngleWidth-1:0] WRAP_HIGH   = 16'sd16000;
   localparam logic [DivCntWidth-1:0] DIV_STEPS = 5'd26;

   localparam logic [CsrIdxWidth-1:0] CSR_WINDOW_ENABLE = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_HIGH_MIN      = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_HIGH_MAX      = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PERIOD_MAX    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_JUMP_LIMIT    = 3'd4;

   localparam logic [CountWidth-1:0] HIGH_MIN_RST   = 16'd250;
   localparam logic [CountWidth-1:0] HIGH_MAX_RST   = 16'd1750;
   localparam logic [CountWidth-1:0] PERIOD_MAX_RST = 16'd2200;
   localparam logic [JumpWidth-1:0]  JUMP_LIMIT_RST = 15'd5000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_START,
      ST_ANGLE,
      ST_EMIT
   } pasm_state_type;

   typedef struct packed {
      logic                         done;
      logic signed [AngleWidth-1:0] change;
      logic [TotalWidth-1:0]        total;
   } pasm_ang_type;

endpackage

// ----- sv/pwm_angle_sensor_multiturn.sv -----
// ----------------------------------------------------------------------------
// PWM angle sensor with multi-turn unwrap
// Qualifies each PWM capture, derives the held duty in permille with a
// bit-serial divider and accumulates a wrapping multi-turn angle.
//
//   Channel  Direction  Handshake        Beat contents
//   req_     in         valid / stall    period_count, high_count
//   rsp_     out        valid / stall    duty_permille, duty_updated,
//                                        angle_total, angle_change
//   csr_     in         valid / ready    csr_index, csr_data
//
// A qualifying capture runs through the 26 steps of the one-bit-per-cycle
// divider before the angle unwrap; a capture that does not qualify skips
// the divider and goes straight to the unwrap. One capture is in work
// at a time, and req_stall is high until its result sits in the output
// register, which may still wait on rsp_stall while the next capture enters.
// Reset is synchronous and restores the register defaults and zero state.
// ----------------------------------------------------------------------------
module pwm_angle_sensor_multiturn
   import pasm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [CountWidth-1:0]        req_period_count,
   input  logic [CountWidth-1:0]        req_high_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [DutyWidth-1:0]         rsp_duty_permille,
   output logic                         rsp_duty_updated,
   output logic signed [TotalWidth-1:0] rsp_angle_total,
   output logic signed [AngleWidth-1:0] rsp_angle_change,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CsrIdxWidth-1:0]       csr_index,
   input  logic [CountWidth-1:0]        csr_data
);

   pasm_state_type state_ff, state_in;

   logic                  win_en_ff;
   logic [CountWidth-1:0] high_min_ff, high_max_ff, period_max_ff;
   logic [JumpWidth-1:0]  jump_limit_ff;
   logic [DutyWidth-1:0]  held_duty_ff;
   logic                  ok_ff;
   logic                  rsp_valid_ff;
   logic [DutyWidth-1:0]  rsp_duty_ff;
   logic                  rsp_upd_ff;
   logic [TotalWidth-1:0] rsp_total_ff;
   logic [AngleWidth-1:0] rsp_change_ff;

   logic                  accept;
   logic                  ok;
   logic                  div_load;
   logic                  div_done;
   logic [DutyWidth-1:0]  div_duty;
   logic                  ang_start;
   logic                  out_load;
   logic                  out_free;
   pasm_ang_type          ang;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ok = (req_period_count != '0) &&
               (!win_en_ff || (req_period_count < period_max_ff &&
                               req_high_count < high_max_ff &&
                               req_high_count > high_min_ff));
   assign div_load = accept && ok;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ok ? ST_DIVIDE : ST_START;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_ANGLE;
         ST_ANGLE: begin
            if (ang.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      ang_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_DIVIDE: ;
         ST_START:  ang_start = 1'b1;
         ST_ANGLE:  ;
         ST_EMIT:   out_load = out_free;
         default:   ;
      endcase
   end

   pasm_div u_div (
      .clock  (clock),
      .reset  (reset),
      .load   (div_load),
      .period (req_period_count),
      .high   (req_high_count),
      .done   (div_done),
      .duty   (div_duty)
   );

   pasm_unwrap u_unwrap (
      .clock      (clock),
      .reset      (reset),
      .start      (ang_start),
      .duty       (held_duty_ff),
      .jump_limit (jump_limit_ff),
      .result     (ang)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         win_en_ff     <= 1'b1;
         high_min_ff   <= HIGH_MIN_RST;
         high_max_ff   <= HIGH_MAX_RST;
         period_max_ff <= PERIOD_MAX_RST;
         jump_limit_ff <= JUMP_LIMIT_RST;
         held_duty_ff  <= '0;
         ok_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_WINDOW_ENABLE: win_en_ff     <= csr_data[0];
               CSR_HIGH_MIN:      high_min_ff   <= csr_data;
               CSR_HIGH_MAX:      high_max_ff   <= csr_data;
               CSR_PERIOD_MAX:    period_max_ff <= csr_data;
               CSR_JUMP_LIMIT:    jump_limit_ff <= csr_data[JumpWidth-1:0];
               default:           ;
            endcase
         end
         if (accept) begin
            ok_ff <= ok;
         end
         if (state_ff == ST_DIVIDE && div_done) begin
            held_duty_ff <= div_duty;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (out_load) begin
         rsp_duty_ff   <= held_duty_ff;
         rsp_upd_ff    <= ok_ff;
         rsp_total_ff  <= ang.total;
         rsp_change_ff <= ang.change;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty_permille = rsp_duty_ff;
   assign rsp_duty_updated  = rsp_upd_ff;
   assign rsp_angle_total   = rsp_total_ff;
   assign rsp_angle_change  = rsp_change_ff;

endmodule

// ----- sv/pasm_div.sv -----
// ----------------------------------------------------------------------------
// PWM angle sensor duty divider
// Bit-serial restoring divider that forms high*1000/period one quotient bit
// per cycle and saturates the result at full duty.
// ----------------------------------------------------------------------------
module pasm_div
   import pasm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [CountWidth-1:0] period,
   input  logic [CountWidth-1:0] high,
   output logic                  done,
   output logic [DutyWidth-1:0]  duty
);

   logic [DvdWidth-1:0]    dvd_ff,    dvd_in;
   logic [DvdWidth-1:0]    quo_ff,    quo_in;
   logic [CountWidth-1:0]  rem_ff,    rem_in;
   logic [CountWidth-1:0]  div_ff,    div_in;
   logic [DivCntWidth-1:0] count_ff,  count_in;
   logic                   done_ff,   done_in;
   logic [CountWidth:0]    trial;
   logic [CountWidth:0]    diff;
   logic [DvdWidth-1:0]    product;

   // high * 1000 = high * 1024 - high * 16 - high * 8
   assign product = {high, 10'b0} - {6'b0, high, 4'b0} - {7'b0, high, 3'b0};
   assign trial   = {rem_ff, dvd_ff[DvdWidth-1]};
   assign diff    = trial - {1'b0, div_ff};

   always_comb begin
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (load) begin
         dvd_in   = product;
         quo_in   = '0;
         rem_in   = '0;
         div_in   = period;
         count_in = DIV_STEPS;
      end else if (count_ff != '0) begin
         dvd_in   = {dvd_ff[DvdWidth-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == 5'd1);
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[CountWidth-1:0];
            quo_in = {quo_ff[DvdWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[CountWidth-1:0];
            quo_in = {quo_ff[DvdWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign duty = (quo_ff > DUTY_FULL_Q) ? DUTY_FULL : quo_ff[DutyWidth-1:0];

endmodule

// ----- sv/pasm_unwrap.sv -----
// ----------------------------------------------------------------------------
// PWM angle sensor unwrap
// Three-stage step that turns the held duty into a single-turn angle,
// corrects the change for a wrap, drops large forward jumps and accumulates
// the wrapping multi-turn total.
// ----------------------------------------------------------------------------
module pasm_unwrap
   import pasm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DutyWidth-1:0] duty,
   input  logic [JumpWidth-1:0] jump_limit,
   output pasm_ang_type         result
);

   logic                         s1_ff, s2_ff, s3_ff;
   logic signed [AngleWidth-1:0] now_ff, now_in;
   logic signed [AngleWidth-1:0] last_ff;
   logic signed [AngleWidth-1:0] change_ff, change_in;
   logic [TotalWidth-1:0]        total_ff, total_in;
   logic signed [AngleWidth-1:0] offs;
   logic signed [AngleWidth:0]   diff;
   logic signed [AngleWidth:0]   delta;

   assign offs   = $signed({6'b0, duty}) - DUTY_OFFSET;
   assign now_in = (offs <<< 4) + (offs <<< 3);

   always_comb begin
      diff = {now_ff[AngleWidth-1], now_ff} - {last_ff[AngleWidth-1], last_ff};
      delta = diff;
      if (now_ff < WRAP_LOW && last_ff > WRAP_HIGH) begin
         delta = diff + SPAN_CD;
      end
      if (now_ff > WRAP_HIGH && last_ff < WRAP_LOW) begin
         delta = diff - SPAN_CD;
      end
      if (delta > $signed({2'b0, jump_limit})) begin
         delta = '0;
      end
      change_in = delta[AngleWidth-1:0];
   end

   assign total_in = total_ff + {{(TotalWidth-AngleWidth){change_ff[AngleWidth-1]}}, change_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff    <= 1'b0;
         s2_ff    <= 1'b0;
         s3_ff    <= 1'b0;
         last_ff  <= '0;
         total_ff <= '0;
      end else begin
         s1_ff <= start;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         if (s1_ff) begin
            last_ff <= now_ff;
         end
         if (s2_ff) begin
            total_ff <= total_in;
         end
      end
      if (start) begin
         now_ff <= now_in;
      end
      if (s1_ff) begin
         change_ff <= change_in;
      end
   end

   assign result.done   = s3_ff;
   assign result.change = change_ff;
   assign result.total  = total_ff;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PWM angle sensor multi-turn testbench
// Drives PWM captures into the block and checks every result beat against
// a behavioral model of duty qualification, the held duty, and the angle
// unwrap, or for typed rows against the beat in the stimulus table. That
// short table covers reset values, window edges, saturation and both wrap
// directions. It is followed by randomized phases under several register
// settings, with bursty request traffic and patterned response stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import pasm_pkg::*;

   localparam int CENTIDEG_PER_PERMILLE = 24;
   localparam int SETTLE_CYCLES         = 4;
   localparam int TAIL_CYCLES           = 40;
   localparam int IDLE_LIMIT            = 4000;
   localparam int MAX_REPORTS           = 10;
   localparam int DIRECTED_COUNT        = 21;
   localparam int PHASE_COUNT           = 6;
   localparam logic [CsrIdxWidth-1:0] CSR_SPARE_IDX = 3'd7;

   typedef struct packed {
      logic [DutyWidth-1:0]         duty;
      logic                         updated;
      logic signed [TotalWidth-1:0] total;
      logic signed [AngleWidth-1:0] change;
   } angle_beat_type;

   typedef struct packed {
      logic                  relaxed;
      logic [CountWidth-1:0] period;
      logic [CountWidth-1:0] high;
      logic                  typed;
      angle_beat_type        beat;
   } capture_row_type;

   typedef enum logic [2:0] {
      SET_DEFAULT,
      SET_OPEN,
      SET_WIDE,
      SET_CLOSED,
      SET_RANDOM,
      SET_LOOSE
   } setting_kind_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_BLOCKS
   } stall_mode_type;

   localparam capture_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{1'b0, 16'd0,     16'd0,     1'b1, '{10'd0,   1'b0, -32'sd3000,  -16'sd3000}},
      '{1'b0, 16'd0,     16'd65535, 1'b1, '{10'd0,   1'b0, -32'sd3000,  16'sd0}},
      '{1'b0, 16'd2000,  16'd1000,  1'b1, '{10'd500, 1'b1, -32'sd3000,  16'sd0}},
      '{1'b0, 16'd2000,  16'd250,   1'b1, '{10'd500, 1'b0, -32'sd3000,  16'sd0}},
      '{1'b0, 16'd2000,  16'd251,   1'b1, '{10'd125, 1'b1, -32'sd12000, -16'sd9000}},
      '{1'b0, 16'd2200,  16'd1000,  1'b1, '{10'd125, 1'b0, -32'sd12000, 16'sd0}},
      '{1'b0, 16'd2199,  16'd1749,  1'b0, '0},
      '{1'b0, 16'd2000,  16'd300,   1'b0, '0},
      '{1'b0, 16'd2000,  16'd1750,  1'b0, '0},
      '{1'b0, 16'd1,     16'd1,     1'b0, '0},
      '{1'b0, 16'd2000,  16'd1200,  1'b0, '0},
      '{1'b0, 16'd2000,  16'd400,   1'b0, '0},
      '{1'b1, 16'd1,     16'd65535, 1'b0, '0},
      '{1'b1, 16'd65535, 16'd0,     1'b0, '0},
      '{1'b1, 16'd65535, 16'd65535, 1'b0, '0},
      '{1'b1, 16'd0,     16'd12345, 1'b0, '0},
      '{1'b1, 16'd3,     16'd2,     1'b0, '0},
      '{1'b1, 16'd1000,  16'd999,   1'b0, '0},
      '{1'b1, 16'd65535, 16'd1,     1'b0, '0},
      '{1'b1, 16'd1000,  16'd208,   1'b0, '0},
      '{1'b1, 16'd1000,  16'd792,   1'b0, '0}
   };

   localparam setting_kind_type PHASE_PLAN [PHASE_COUNT] = '{
      SET_DEFAULT, SET_OPEN, SET_WIDE, SET_CLOSED, SET_RANDOM, SET_LOOSE
   };
   localparam int PHASE_ITEMS [PHASE_COUNT] = '{110, 100, 110, 40, 120, 120};

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [CountWidth-1:0]        req_period_count = '0;
   logic [CountWidth-1:0]        req_high_count = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [DutyWidth-1:0]         rsp_duty_permille;
   logic                         rsp_duty_updated;
   logic signed [TotalWidth-1:0] rsp_angle_total;
   logic signed [AngleWidth-1:0] rsp_angle_change;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CsrIdxWidth-1:0]       csr_index = '0;
   logic [CountWidth-1:0]        csr_data = '0;

   logic                  cfg_window;
   logic [CountWidth-1:0] cfg_high_min;
   logic [CountWidth-1:0] cfg_high_max;
   logic [CountWidth-1:0] cfg_period_max;
   logic [JumpWidth-1:0]  cfg_jump_limit;

   logic [DutyWidth-1:0]  held_duty;
   int                    last_angle;
   logic [TotalWidth-1:0] total_angle;

   angle_beat_type angle_beats_due [$];

   int             burst_left;
   int             captures_sent;
   int             beats_seen = 0;
   int             qualified_count;
   int             wrap_fwd_count;
   int             wrap_back_count;
   int             dropped_count;
   int             settings_count;
   int             mismatch_count = 0;
   int             fail_count = 0;
   int             idle_cycles = 0;
   stall_mode_type stall_mode;
   logic [7:0]     stall_tick;

   pwm_angle_sensor_multiturn DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_period_count  (req_period_count),
      .req_high_count    (req_high_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_duty_permille (rsp_duty_permille),
      .rsp_duty_updated  (rsp_duty_updated),
      .rsp_angle_total   (rsp_angle_total),
      .rsp_angle_change  (rsp_angle_change),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic angle_beat_type unwrap_capture(input logic [CountWidth-1:0] period,
                                                     input logic [CountWidth-1:0] high);
      angle_beat_type beat;
      logic           ok;
      int             quot;
      int             now;
      int             delta;
      ok = (period != '0);
      if (ok && cfg_window) begin
         ok = (period < cfg_period_max) && (high < cfg_high_max) && (high > cfg_high_min);
      end
      if (ok) begin
         quot = (int'(high) * int'(DUTY_FULL)) / int'(period);
         held_duty = (quot > int'(DUTY_FULL)) ? DUTY_FULL : quot[DutyWidth-1:0];
         qualified_count++;
      end
      now = (int'(held_duty) - int'(DUTY_OFFSET)) * CENTIDEG_PER_PERMILLE;
      delta = now - last_angle;
      if (now < int'(WRAP_LOW) && last_angle > int'(WRAP_HIGH)) begin
         delta = now + int'(SPAN_CD) - last_angle;
         wrap_fwd_count++;
      end
      if (now > int'(WRAP_HIGH) && last_angle < int'(WRAP_LOW)) begin
         delta = now - (last_angle + int'(SPAN_CD));
         wrap_back_count++;
      end
      if (delta > int'(cfg_jump_limit)) begin
         delta = 0;
         dropped_count++;
      end
      total_angle = total_angle + TotalWidth'(delta);
      last_angle = now;
      beat.duty = held_duty;
      beat.updated = ok;
      beat.total = total_angle;
      beat.change = AngleWidth'(delta);
      return beat;
   endfunction

   function automatic logic [2*CountWidth-1:0] pick_capture();
      int unsigned period;
      int unsigned high;
      int unsigned duty;
      int unsigned lo;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         period = (r < 4) ? 0 : $urandom_range(0, 65535);
         return {CountWidth'(period), CountWidth'($urandom)};
      end
      if (r < 55) begin
         duty = $urandom_range(0, 1000);
      end else if (r < 77) begin
         duty = $urandom_range(0, 208);
      end else begin
         duty = $urandom_range(792, 1000);
      end
      if (cfg_window && cfg_period_max > 1) begin
         lo = (cfg_period_max / 2 < 1) ? 1 : cfg_period_max / 2;
         period = $urandom_range(lo, cfg_period_max - 1);
      end else begin
         period = $urandom_range(1, 65535);
      end
      high = (duty * period + 999) / 1000;
      if (r >= 95) begin
         high = period + $urandom_range(0, 2000);
      end
      if (high > 65535) begin
         high = 65535;
      end
      return {CountWidth'(period), CountWidth'(high)};
   endfunction

   task automatic issue_capture(input logic [CountWidth-1:0] period,
                                input logic [CountWidth-1:0] high,
                                input logic typed, input angle_beat_type typed_beat);
      angle_beat_type predicted;
      int             gap;
      req_valid <= 1'b1;
      req_period_count <= period;
      req_high_count <= high;
      do @(posedge clock); while (req_stall);
      predicted = unwrap_capture(period, high);
      angle_beats_due.push_back(typed ? typed_beat : predicted);
      captures_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (angle_beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CountWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WINDOW_ENABLE: cfg_window = data[0];
         CSR_HIGH_MIN:      cfg_high_min = data;
         CSR_HIGH_MAX:      cfg_high_max = data;
         CSR_PERIOD_MAX:    cfg_period_max = data;
         CSR_JUMP_LIMIT:    cfg_jump_limit = data[JumpWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic win, input logic [CountWidth-1:0] hmin,
                                 input logic [CountWidth-1:0] hmax,
                                 input logic [CountWidth-1:0] pmax,
                                 input logic [CountWidth-1:0] jump_data, input logic spare);
      write_reg(CSR_WINDOW_ENABLE, {15'($urandom), win});
      write_reg(CSR_HIGH_MIN, hmin);
      write_reg(CSR_HIGH_MAX, hmax);
      write_reg(CSR_PERIOD_MAX, pmax);
      write_reg(CSR_JUMP_LIMIT, jump_data);
      if (spare) begin
         write_reg(CSR_SPARE_IDX, CountWidth'($urandom));
      end
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= STALL_NONE;
         stall_tick <= '0;
      end else begin
         stall_tick <= stall_tick + 8'd1;
         if (stall_tick[5:0] == '0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 2));
         end
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
            default:      rsp_stall <= (stall_tick[4:0] < 5'd20);
         endcase
      end
   end

   always @(posedge clock) begin
      angle_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (angle_beats_due.size() == 0) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected result beat %0d: duty %0d upd %0b total %0d change %0d",
                        beats_seen, rsp_duty_permille, rsp_duty_updated, rsp_angle_total,
                        rsp_angle_change);
            end
         end else begin
            want = angle_beats_due.pop_front();
            if (rsp_duty_permille !== want.duty || rsp_duty_updated !== want.updated ||
                rsp_angle_total !== want.total || rsp_angle_change !== want.change) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("beat %0d: expected duty %0d upd %0b total %0d change %0d",
                           beats_seen, want.duty, want.updated, want.total, want.change);
                  $display("beat %0d:      got duty %0d upd %0b total %0d change %0d",
                           beats_seen, rsp_duty_permille, rsp_duty_updated,
                           rsp_angle_total, rsp_angle_change);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, angle_beats_due.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [2*CountWidth-1:0] capture;
      logic                    relaxed_now;
      int                      items;
      cfg_window = 1'b1;
      cfg_high_min = HIGH_MIN_RST;
      cfg_high_max = HIGH_MAX_RST;
      cfg_period_max = PERIOD_MAX_RST;
      cfg_jump_limit = JUMP_LIMIT_RST;
      held_duty = '0;
      last_angle = 0;
      total_angle = '0;
      burst_left = $urandom_range(1, 20);
      captures_sent = 0;
      qualified_count = 0;
      wrap_fwd_count = 0;
      wrap_back_count = 0;
      dropped_count = 0;
      settings_count = 0;
      relaxed_now = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int row = 0; row < DIRECTED_COUNT; row++) begin
         if (DIRECTED_ROWS[row].relaxed != relaxed_now) begin
            drain_results();
            apply_settings(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
            relaxed_now = DIRECTED_ROWS[row].relaxed;
         end
         issue_capture(DIRECTED_ROWS[row].period, DIRECTED_ROWS[row].high,
                       DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].beat);
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain_results();
         case (PHASE_PLAN[ph])
            SET_DEFAULT: apply_settings(1'b1, HIGH_MIN_RST, HIGH_MAX_RST, PERIOD_MAX_RST,
                                        CountWidth'(JUMP_LIMIT_RST), 1'b0);
            SET_OPEN:    apply_settings(1'b0, CountWidth'($urandom), CountWidth'($urandom),
                                        CountWidth'($urandom), 16'hFFFF, 1'b0);
            SET_WIDE:    apply_settings(1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
            SET_CLOSED:  apply_settings(1'b1, 16'hFFFF, 16'h0000, 16'h0000,
                                        CountWidth'($urandom), 1'b0);
            SET_RANDOM:  apply_settings(1'($urandom), CountWidth'($urandom_range(0, 1000)),
                                        CountWidth'($urandom_range(500, 3000)),
                                        CountWidth'($urandom_range(1000, 4000)),
                                        CountWidth'($urandom), 1'b1);
            default:     apply_settings(1'b0, CountWidth'($urandom), CountWidth'($urandom),
                                        CountWidth'($urandom),
                                        CountWidth'($urandom_range(0, 8000)), 1'b0);
         endcase
         items = PHASE_ITEMS[ph];
         for (int k = 0; k < items; k++) begin
            if (k == items / 2) begin
               drain_results();
            end
            capture = pick_capture();
            issue_capture(capture[2*CountWidth-1:CountWidth], capture[CountWidth-1:0],
                          1'b0, '0);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (angle_beats_due.size() != 0) begin
         $display("%0d expected results never arrived", angle_beats_due.size());
      end
      $display("Sent %0d captures (%0d qualified) over %0d register settings.",
               captures_sent, qualified_count, settings_count);
      $display("Saw %0d forward and %0d backward wraps, %0d dropped jumps, %0d mismatches.",
               wrap_fwd_count, wrap_back_count, dropped_count, mismatch_count);
      if (fail_count == 0 && angle_beats_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/pasm_pkg.sv
sv/pasm_div.sv
sv/pasm_unwrap.sv
sv/pwm_angle_sensor_multiturn.sv
tb/tb_top.sv
